>>> hdl/psue_pkg.sv
// ----------------------------------------------------------------------------
// Particle swarm update engine package
// Shared widths, reset values, action and register codes, and the move
// datapath settings struct.
// ----------------------------------------------------------------------------
package psue_pkg;

	localparam int VAL_W   = 16;
	localparam int FIT_W   = 32;
	localparam int IDX_W   = 6;
	localparam int GAIN_W  = 16;
	localparam int LIM_W   = 15;
	localparam int DIMS_W  = 7;
	localparam int CFG_IDX_W = 3;

	localparam int MAX_PARTICLES_DEF = 64;
	localparam int MAX_DIMS_DEF      = 64;

	localparam logic [1:0] ACT_CLEAR  = 2'd0;
	localparam logic [1:0] ACT_LOAD   = 2'd1;
	localparam logic [1:0] ACT_MOVE   = 2'd2;
	localparam logic [1:0] ACT_REPORT = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_INERTIA   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COGNITIVE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SOCIAL    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LOWER     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_UPPER     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SPAN      = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_DIMS      = 3'd7;

	localparam logic [GAIN_W-1:0]       RST_INERTIA   = 16'd2867;
	localparam logic [GAIN_W-1:0]       RST_COGNITIVE = 16'd6144;
	localparam logic [GAIN_W-1:0]       RST_SOCIAL    = 16'd6144;
	localparam logic [LIM_W-1:0]        RST_SPEED     = 15'd8192;
	localparam logic signed [VAL_W-1:0] RST_LOWER     = -16'sd4096;
	localparam logic signed [VAL_W-1:0] RST_UPPER     = 16'sd4096;
	localparam logic [LIM_W-1:0]        RST_SPAN      = 15'd8192;
	localparam logic [DIMS_W-1:0]       RST_DIMS      = 7'd64;

	localparam logic [FIT_W-1:0] FIT_WORST = '1;

	typedef struct packed {
		logic [GAIN_W-1:0]       inertia;
		logic [GAIN_W-1:0]       cognitive;
		logic [GAIN_W-1:0]       social;
		logic [LIM_W-1:0]        speed;
		logic signed [VAL_W-1:0] lower;
		logic signed [VAL_W-1:0] upper;
		logic [LIM_W-1:0]        span;
	} move_cfg_t;

endpackage

>>> hdl/psue_move.sv
// ----------------------------------------------------------------------------
// Particle swarm move datapath
// Three-stage pipeline: random-scaled gains and inertia product, pull
// products, then sum, round, clamp; the position wrap closes the last stage.
// ----------------------------------------------------------------------------
module psue_move (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              go,
	input  psue_pkg::move_cfg_t               cfg,
	input  logic [psue_pkg::GAIN_W-1:0]       rand_own,
	input  logic [psue_pkg::GAIN_W-1:0]       rand_swarm,
	input  logic signed [psue_pkg::VAL_W-1:0] pos,
	input  logic signed [psue_pkg::VAL_W-1:0] vel,
	input  logic signed [psue_pkg::VAL_W-1:0] own_best,
	input  logic signed [psue_pkg::VAL_W-1:0] swarm_best,
	output logic                              done,
	output logic signed [psue_pkg::VAL_W-1:0] vel_out,
	output logic signed [psue_pkg::VAL_W-1:0] pos_out
);

	logic [2:0] vld_q;

	logic [15:0]        g1_s1, g2_s1;
	logic signed [16:0] down_s1, dswm_s1;
	logic signed [32:0] a_s1, a_s2;
	logic signed [15:0] pos_s1, pos_s2, pos_s3;
	logic signed [33:0] b_s2, c_s2;
	logic signed [15:0] v_s3;

	logic [31:0]        g1_full, g2_full;
	logic signed [35:0] sum;
	logic signed [23:0] t;
	logic signed [23:0] lim;
	logic signed [17:0] q0, q1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[1:0], go};
		end
	end

	assign g1_full = cfg.cognitive * rand_own;
	assign g2_full = cfg.social * rand_swarm;

	always_ff @(posedge clk) begin
		g1_s1   <= g1_full[31:16];
		g2_s1   <= g2_full[31:16];
		down_s1 <= 17'(own_best) - 17'(pos);
		dswm_s1 <= 17'(swarm_best) - 17'(pos);
		a_s1    <= $signed({1'b0, cfg.inertia}) * vel;
		pos_s1  <= pos;

		b_s2   <= $signed({1'b0, g1_s1}) * down_s1;
		c_s2   <= $signed({1'b0, g2_s1}) * dswm_s1;
		a_s2   <= a_s1;
		pos_s2 <= pos_s1;

		v_s3   <= vel_out_c(t, lim);
		pos_s3 <= pos_s2;
	end

	// Round to nearest at scale 2^-12; the arithmetic shift floors.
	assign sum = 36'(a_s2) + 36'(b_s2) + 36'(c_s2) + 36'sd2048;
	assign t   = sum[35:12];
	assign lim = 24'($signed({1'b0, cfg.speed}));

	function automatic logic signed [15:0] vel_out_c(input logic signed [23:0] tv,
		input logic signed [23:0] lv);
		logic signed [15:0] r;
		if (tv < lv && tv > -lv) begin
			r = tv[15:0];
		end else if (tv >= 0) begin
			r = lv[15:0];
		end else begin
			r = 16'(-lv);
		end
		return r;
	endfunction

	always_comb begin
		q0 = 18'(pos_s3) + 18'(v_s3);
		if (q0 > 18'(cfg.upper)) begin
			q1 = q0 - 18'($signed({1'b0, cfg.span}));
		end else if (q0 < 18'(cfg.lower)) begin
			q1 = q0 + 18'($signed({1'b0, cfg.span}));
		end else begin
			q1 = q0;
		end
		if (q1 > 18'sd32767) begin
			pos_out = 16'sh7fff;
		end else if (q1 < -18'sd32768) begin
			pos_out = 16'sh8000;
		end else begin
			pos_out = q1[15:0];
		end
	end

	assign vel_out = v_s3;
	assign done    = vld_q[2];

endmodule

>>> hdl/particle_swarm_update_engine_core.sv
// ----------------------------------------------------------------------------
// Particle swarm update engine core
// Position, velocity and personal-best stores in synchronous RAM, one item at
// a time: clear, load, move and fitness report with personal-best row copy.
// ----------------------------------------------------------------------------
// A move reads memory and then passes the three-stage move datapath; an improving
// report copies min(dims_in_use, MAX_DIMS) elements of the row, the copy going
// through the single position read port one element a cycle.
// One item at a time: in_ready returns the cycle after the result is registered.
// Reset: best fitnesses all ones, global best 0, registers at defaults, stores kept.
module particle_swarm_update_engine_core #(
	parameter int MAX_PARTICLES = psue_pkg::MAX_PARTICLES_DEF,
	parameter int MAX_DIMS      = psue_pkg::MAX_DIMS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [psue_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [15:0]                           cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [1:0]                            action,
	input  logic [psue_pkg::IDX_W-1:0]            particle,
	input  logic [psue_pkg::IDX_W-1:0]            dim_index,
	input  logic signed [psue_pkg::VAL_W-1:0]     position_in,
	input  logic signed [psue_pkg::VAL_W-1:0]     velocity_in,
	input  logic [psue_pkg::GAIN_W-1:0]           rand_own,
	input  logic [psue_pkg::GAIN_W-1:0]           rand_swarm,
	input  logic [psue_pkg::FIT_W-1:0]            fitness,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [psue_pkg::VAL_W-1:0]     new_position,
	output logic signed [psue_pkg::VAL_W-1:0]     new_velocity,
	output logic [psue_pkg::IDX_W-1:0]            best_particle,
	output logic [psue_pkg::FIT_W-1:0]            best_fitness,
	output logic                                  improved
);

	localparam int PW    = $clog2(MAX_PARTICLES);
	localparam int DW    = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
	localparam int CW    = $clog2(MAX_DIMS + 1);
	localparam int AW    = PW + DW;
	localparam int DEPTH = 2 ** AW;
	localparam int PDEPTH = 2 ** PW;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RD   = 3'd1;
	localparam logic [2:0] ST_MV   = 3'd2;
	localparam logic [2:0] ST_FT   = 3'd3;
	localparam logic [2:0] ST_CP   = 3'd4;
	localparam logic [2:0] ST_FIN  = 3'd5;

	// Configuration
	psue_pkg::move_cfg_t                 mcfg_q;
	logic [psue_pkg::DIMS_W-1:0]         dims_q;

	// Accepted item
	logic [1:0]                          act_q;
	logic [psue_pkg::IDX_W-1:0]          p_q, d_q;
	logic signed [psue_pkg::VAL_W-1:0]   posin_q, velin_q;
	logic [psue_pkg::GAIN_W-1:0]         ro_q, rs_q;
	logic [psue_pkg::FIT_W-1:0]          fit_q;

	// Control
	logic [2:0]                          state_q;
	logic                                mv_go_q;
	logic [PW-1:0]                       swarm_q;
	logic [psue_pkg::FIT_W-1:0]          swarm_fit_q;
	logic [PDEPTH-1:0]                   fvld_q;
	logic [CW-1:0]                       k_q;
	logic                                wv_s1;
	logic [DW-1:0]                       wk_s1;

	// Result staging
	logic signed [psue_pkg::VAL_W-1:0]   res_pos_q, res_vel_q;
	logic                                res_imp_q;

	// Memories
	logic [psue_pkg::VAL_W-1:0] pos_mem [DEPTH];
	logic [psue_pkg::VAL_W-1:0] vel_mem [DEPTH];
	logic [psue_pkg::VAL_W-1:0] ob_mem  [DEPTH];
	logic [psue_pkg::FIT_W-1:0] fit_mem [PDEPTH];
	logic [psue_pkg::VAL_W-1:0] pos_rd_q, vel_rd_q, ob_rd_q, obg_rd_q;
	logic [psue_pkg::FIT_W-1:0] fit_rd_q;

	logic [PW-1:0]  pidx;
	logic [DW-1:0]  didx;
	logic [AW-1:0]  e_addr, pos_raddr;
	logic           p_ok, d_ok;
	logic [CW-1:0]  n_c;
	logic [psue_pkg::FIT_W-1:0] own_fit_c;
	logic           better_c;

	logic           pos_we, vel_we, ob_we, fit_we;
	logic [psue_pkg::VAL_W-1:0] pos_wd, vel_wd;

	logic                              mv_done;
	logic signed [psue_pkg::VAL_W-1:0] mv_vel, mv_pos;

	logic           in_fire, out_free;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_free  = !out_valid || out_ready;

	assign pidx   = PW'(p_q);
	assign didx   = DW'(d_q);
	assign e_addr = {pidx, didx};
	assign p_ok   = 32'(p_q) < 32'(MAX_PARTICLES);
	assign d_ok   = 32'(d_q) < 32'(MAX_DIMS);
	assign n_c    = (32'(dims_q) < 32'(MAX_DIMS)) ? CW'(dims_q) : CW'(MAX_DIMS);
	assign pos_raddr = (state_q == ST_CP) ? {pidx, k_q[DW-1:0]} : e_addr;

	assign own_fit_c = fvld_q[pidx] ? fit_rd_q : psue_pkg::FIT_WORST;
	assign better_c  = fit_q < own_fit_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mcfg_q.inertia   <= psue_pkg::RST_INERTIA;
			mcfg_q.cognitive <= psue_pkg::RST_COGNITIVE;
			mcfg_q.social    <= psue_pkg::RST_SOCIAL;
			mcfg_q.speed     <= psue_pkg::RST_SPEED;
			mcfg_q.lower     <= psue_pkg::RST_LOWER;
			mcfg_q.upper     <= psue_pkg::RST_UPPER;
			mcfg_q.span      <= psue_pkg::RST_SPAN;
			dims_q           <= psue_pkg::RST_DIMS;
		end else if (cfg_valid) begin
			case (cfg_index)
				psue_pkg::REG_INERTIA:   mcfg_q.inertia   <= cfg_data;
				psue_pkg::REG_COGNITIVE: mcfg_q.cognitive <= cfg_data;
				psue_pkg::REG_SOCIAL:    mcfg_q.social    <= cfg_data;
				psue_pkg::REG_SPEED:     mcfg_q.speed     <= cfg_data[14:0];
				psue_pkg::REG_LOWER:     mcfg_q.lower     <= cfg_data;
				psue_pkg::REG_UPPER:     mcfg_q.upper     <= cfg_data;
				psue_pkg::REG_SPAN:      mcfg_q.span      <= cfg_data[14:0];
				psue_pkg::REG_DIMS:      dims_q           <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			act_q   <= action;
			p_q     <= particle;
			d_q     <= dim_index;
			posin_q <= position_in;
			velin_q <= velocity_in;
			ro_q    <= rand_own;
			rs_q    <= rand_swarm;
			fit_q   <= fitness;
		end
	end

	psue_move u_move (
		.clk        (clk),
		.arst_n     (arst_n),
		.go         (mv_go_q),
		.cfg        (mcfg_q),
		.rand_own   (ro_q),
		.rand_swarm (rs_q),
		.pos        (pos_rd_q),
		.vel        (vel_rd_q),
		.own_best   (ob_rd_q),
		.swarm_best (obg_rd_q),
		.done       (mv_done),
		.vel_out    (mv_vel),
		.pos_out    (mv_pos)
	);

	// Memory write controls
	always_comb begin
		pos_we = 1'b0;
		vel_we = 1'b0;
		pos_wd = posin_q;
		vel_wd = velin_q;
		if (state_q == ST_RD && act_q == psue_pkg::ACT_LOAD && p_ok && d_ok) begin
			pos_we = 1'b1;
			vel_we = 1'b1;
		end else if (state_q == ST_MV && mv_done) begin
			pos_we = 1'b1;
			vel_we = 1'b1;
			pos_wd = mv_pos;
			vel_wd = mv_vel;
		end
	end

	assign ob_we  = wv_s1;
	assign fit_we = (state_q == ST_FT) && better_c;

	always_ff @(posedge clk) begin
		if (pos_we) begin
			pos_mem[e_addr] <= pos_wd;
		end
		pos_rd_q <= pos_mem[pos_raddr];
	end

	always_ff @(posedge clk) begin
		if (vel_we) begin
			vel_mem[e_addr] <= vel_wd;
		end
		vel_rd_q <= vel_mem[e_addr];
	end

	always_ff @(posedge clk) begin
		if (ob_we) begin
			ob_mem[{pidx, wk_s1}] <= pos_rd_q;
		end
		ob_rd_q  <= ob_mem[e_addr];
		obg_rd_q <= ob_mem[{swarm_q, didx}];
	end

	always_ff @(posedge clk) begin
		if (fit_we) begin
			fit_mem[pidx] <= fit_q;
		end
		fit_rd_q <= fit_mem[pidx];
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mv_go_q     <= 1'b0;
			swarm_q     <= '0;
			swarm_fit_q <= psue_pkg::FIT_WORST;
			fvld_q      <= '0;
			k_q         <= '0;
			wv_s1       <= 1'b0;
			wk_s1       <= '0;
			out_valid   <= 1'b0;
		end else begin
			mv_go_q <= 1'b0;
			wv_s1   <= 1'b0;
			if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					case (act_q)
						psue_pkg::ACT_CLEAR: begin
							fvld_q      <= '0;
							swarm_q     <= '0;
							swarm_fit_q <= psue_pkg::FIT_WORST;
							state_q     <= ST_FIN;
						end
						psue_pkg::ACT_MOVE: begin
							if (p_ok && d_ok) begin
								mv_go_q <= 1'b1;
								state_q <= ST_MV;
							end else begin
								state_q <= ST_FIN;
							end
						end
						psue_pkg::ACT_REPORT: begin
							state_q <= p_ok ? ST_FT : ST_FIN;
						end
						default: begin
							state_q <= ST_FIN;
						end
					endcase
				end
				ST_MV: begin
					if (mv_done) begin
						state_q <= ST_FIN;
					end
				end
				ST_FT: begin
					if (better_c) begin
						fvld_q[pidx] <= 1'b1;
						// The global best follows its own particle, or moves here.
						if (pidx == swarm_q) begin
							swarm_fit_q <= fit_q;
						end else if (fit_q < swarm_fit_q) begin
							swarm_q     <= pidx;
							swarm_fit_q <= fit_q;
						end
						k_q     <= '0;
						state_q <= ST_CP;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_CP: begin
					if (k_q < n_c) begin
						wv_s1 <= 1'b1;
						wk_s1 <= k_q[DW-1:0];
						k_q   <= k_q + 1'b1;
					end else if (!wv_s1) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						out_valid <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result staging and output register
	always_ff @(posedge clk) begin
		if (state_q == ST_RD) begin
			res_imp_q <= 1'b0;
			if (act_q == psue_pkg::ACT_LOAD && p_ok && d_ok) begin
				res_pos_q <= posin_q;
				res_vel_q <= velin_q;
			end else begin
				res_pos_q <= '0;
				res_vel_q <= '0;
			end
		end
		if (state_q == ST_MV && mv_done) begin
			res_pos_q <= mv_pos;
			res_vel_q <= mv_vel;
		end
		if (state_q == ST_FT) begin
			res_imp_q <= better_c;
		end
		if (state_q == ST_FIN && out_free) begin
			new_position  <= res_pos_q;
			new_velocity  <= res_vel_q;
			best_particle <= psue_pkg::IDX_W'(swarm_q);
			best_fitness  <= swarm_fit_q;
			improved      <= res_imp_q;
		end
	end

endmodule

>>> dv/tb_particle_swarm_update_engine_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Particle swarm update engine core testbench
// A queue-fed driver sends clear, load, move and fitness report beats with
// random gaps. A clocked monitor checks every result against a predictor that
// keeps its own copy of the stores and registers. Stimulus never makes the
// block read a store entry that has not been written.
// ----------------------------------------------------------------------------
module tb_particle_swarm_update_engine_core;

	localparam int NP          = psue_pkg::MAX_PARTICLES_DEF;
	localparam int ND          = psue_pkg::MAX_DIMS_DEF;
	localparam int WATCH_LIMIT = 4000;
	localparam int SETTLE      = 100;
	localparam int PHASE_ITEMS = 110;

	typedef struct packed {
		logic [1:0]                        act;
		logic [psue_pkg::IDX_W-1:0]        p;
		logic [psue_pkg::IDX_W-1:0]        d;
		logic signed [psue_pkg::VAL_W-1:0] pos;
		logic signed [psue_pkg::VAL_W-1:0] vel;
		logic [psue_pkg::GAIN_W-1:0]       ro;
		logic [psue_pkg::GAIN_W-1:0]       rs;
		logic [psue_pkg::FIT_W-1:0]        fit;
	} swarm_op_t;

	typedef struct packed {
		logic signed [psue_pkg::VAL_W-1:0] npos;
		logic signed [psue_pkg::VAL_W-1:0] nvel;
		logic [psue_pkg::IDX_W-1:0]        bp;
		logic [psue_pkg::FIT_W-1:0]        bf;
		logic                              imp;
	} swarm_res_t;

	logic clk, arst_n;
	logic cfg_valid, cfg_ready;
	logic [psue_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [15:0] cfg_data;
	logic in_valid, in_ready;
	logic [1:0] action;
	logic [psue_pkg::IDX_W-1:0] particle, dim_index;
	logic signed [psue_pkg::VAL_W-1:0] position_in, velocity_in;
	logic [psue_pkg::GAIN_W-1:0] rand_own, rand_swarm;
	logic [psue_pkg::FIT_W-1:0] fitness;
	logic out_valid, out_ready;
	logic signed [psue_pkg::VAL_W-1:0] new_position, new_velocity;
	logic [psue_pkg::IDX_W-1:0] best_particle;
	logic [psue_pkg::FIT_W-1:0] best_fitness;
	logic improved;

	particle_swarm_update_engine_core uut (.*);

	// Predictor copy of the block.
	logic signed [psue_pkg::VAL_W-1:0] pos_m [NP][ND];
	logic signed [psue_pkg::VAL_W-1:0] vel_m [NP][ND];
	logic signed [psue_pkg::VAL_W-1:0] obest_m [NP][ND];
	logic pos_wr [NP][ND];
	logic obest_wr [NP][ND];
	logic [psue_pkg::FIT_W-1:0] obf_m [NP];
	logic [psue_pkg::IDX_W-1:0] gbest_m;
	logic [psue_pkg::GAIN_W-1:0] inertia_r, cog_r, soc_r;
	logic [psue_pkg::LIM_W-1:0] speed_r, span_r;
	logic signed [psue_pkg::VAL_W-1:0] lower_r, upper_r;
	logic [psue_pkg::DIMS_W-1:0] dims_r;

	swarm_op_t swarm_ops[$];
	swarm_res_t expected_beats[$];

	int fails, checked, n_moves, n_loads, n_improved, n_clears;
	int send_gap, recv_gap, idle_cycles;
	logic quiet, in_took;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	function automatic logic signed [psue_pkg::VAL_W-1:0] sat16(longint x);
		if (x > 32767) return 16'sh7fff;
		if (x < -32768) return 16'sh8000;
		return x[psue_pkg::VAL_W-1:0];
	endfunction

	function automatic int copy_len();
		return (dims_r > ND) ? ND : int'(dims_r);
	endfunction

	function automatic swarm_res_t advance_swarm(swarm_op_t it);
		swarm_res_t r;
		longint pv, g1, g2, s, t, lim, v, q;
		int n;
		r = '0;
		case (it.act)
			psue_pkg::ACT_CLEAR: begin
				foreach (obf_m[i]) obf_m[i] = psue_pkg::FIT_WORST;
				gbest_m = '0;
			end
			psue_pkg::ACT_LOAD: begin
				pos_m[it.p][it.d] = it.pos;
				vel_m[it.p][it.d] = it.vel;
				pos_wr[it.p][it.d] = 1'b1;
				r.npos = it.pos;
				r.nvel = it.vel;
			end
			psue_pkg::ACT_MOVE: begin
				pv = pos_m[it.p][it.d];
				g1 = (longint'(cog_r) * longint'(it.ro)) >>> 16;
				g2 = (longint'(soc_r) * longint'(it.rs)) >>> 16;
				s = longint'(inertia_r) * longint'(vel_m[it.p][it.d])
					+ g1 * (longint'(obest_m[it.p][it.d]) - pv)
					+ g2 * (longint'(obest_m[gbest_m][it.d]) - pv);
				t = (s + 2048) >>> 12;
				lim = longint'(speed_r);
				if (t < lim && t > -lim) v = t;
				else v = (t >= 0) ? lim : -lim;
				q = pv + v;
				if (q > longint'(upper_r)) q = q - longint'(span_r);
				else if (q < longint'(lower_r)) q = q + longint'(span_r);
				vel_m[it.p][it.d] = sat16(v);
				pos_m[it.p][it.d] = sat16(q);
				r.npos = pos_m[it.p][it.d];
				r.nvel = vel_m[it.p][it.d];
			end
			default: begin
				if (it.fit < obf_m[it.p]) begin
					n = copy_len();
					obf_m[it.p] = it.fit;
					for (int k = 0; k < n; k++) begin
						obest_m[it.p][k] = pos_m[it.p][k];
						obest_wr[it.p][k] = 1'b1;
					end
					if (it.fit < obf_m[gbest_m]) gbest_m = it.p;
					r.imp = 1'b1;
				end
			end
		endcase
		r.bp = gbest_m;
		r.bf = obf_m[gbest_m];
		return r;
	endfunction

	function automatic void issue(swarm_op_t it);
		swarm_res_t r;
		r = advance_swarm(it);
		if (it.act == psue_pkg::ACT_MOVE) n_moves++;
		if (it.act == psue_pkg::ACT_LOAD) n_loads++;
		if (it.act == psue_pkg::ACT_CLEAR) n_clears++;
		if (r.imp) n_improved++;
		expected_beats.push_back(r);
		swarm_ops.push_back(it);
	endfunction

	function automatic swarm_op_t noise_op();
		swarm_op_t it;
		it.act = 2'($urandom_range(0, 3));
		it.p = 6'($urandom_range(0, 63));
		it.d = 6'($urandom_range(0, 63));
		it.pos = 16'($urandom);
		it.vel = 16'($urandom);
		it.ro = ($urandom_range(0, 7) == 0) ? 16'hffff : 16'($urandom);
		it.rs = ($urandom_range(0, 7) == 0) ? 16'h0000 : 16'($urandom);
		it.fit = $urandom;
		return it;
	endfunction

	function automatic logic [psue_pkg::IDX_W-1:0] pick_particle();
		int r;
		r = $urandom_range(0, 9);
		if (r < 8) return 6'($urandom_range(0, 7));
		if (r == 8) return 6'd63;
		return 6'($urandom_range(0, 63));
	endfunction

	function automatic logic [psue_pkg::IDX_W-1:0] pick_dim();
		if ($urandom_range(0, 4) != 0) return 6'($urandom_range(0, 7));
		return 6'($urandom_range(0, 63));
	endfunction

	function automatic logic row_ready(logic [psue_pkg::IDX_W-1:0] p);
		for (int k = 0; k < copy_len(); k++)
			if (!pos_wr[p][k]) return 1'b0;
		return 1'b1;
	endfunction

	function automatic void gen_random();
		swarm_op_t it;
		int r, sel;
		logic ok;
		it = noise_op();
		it.p = pick_particle();
		it.d = pick_dim();
		sel = $urandom_range(0, 99);
		if (sel < 4) it.act = psue_pkg::ACT_CLEAR;
		else if (sel < 34) it.act = psue_pkg::ACT_LOAD;
		else if (sel < 74) it.act = psue_pkg::ACT_MOVE;
		else it.act = psue_pkg::ACT_REPORT;
		if (it.act == psue_pkg::ACT_MOVE) begin
			ok = 1'b0;
			for (int tries = 0; tries < 8 && !ok; tries++) begin
				if (pos_wr[it.p][it.d] && obest_wr[it.p][it.d] && obest_wr[gbest_m][it.d])
					ok = 1'b1;
				else begin
					it.p = pick_particle();
					it.d = pick_dim();
				end
			end
			if (!ok) it.act = psue_pkg::ACT_LOAD;
		end else if (it.act == psue_pkg::ACT_REPORT) begin
			r = $urandom_range(0, 99);
			if (r < 30) it.fit = $urandom;
			else if (r < 65)
				it.fit = (obf_m[it.p] > 1000) ? obf_m[it.p] - $urandom_range(1, 1000) : '0;
			else if (r < 80) it.fit = obf_m[it.p];
			else if (r < 90) it.fit = (obf_m[gbest_m] > 0) ? obf_m[gbest_m] - 1 : '0;
			else it.fit = ($urandom_range(0, 1) == 0) ? '0 : psue_pkg::FIT_WORST;
			// An improving report copies the row, so that row must be loaded.
			if (it.fit < obf_m[it.p] && !row_ready(it.p)) it.act = psue_pkg::ACT_LOAD;
		end
		issue(it);
	endfunction

	function automatic int pick_gap();
		int r;
		if (quiet) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic report_mismatch(string msg);
		$display("%0t ns: mismatch: %s", $realtime, msg);
		fails++;
	endtask

	task automatic wait_drained();
		while (swarm_ops.size() != 0 || in_valid || expected_beats.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(logic [psue_pkg::CFG_IDX_W-1:0] idx, logic [15:0] data);
		case (idx)
			psue_pkg::REG_INERTIA:   inertia_r = data;
			psue_pkg::REG_COGNITIVE: cog_r = data;
			psue_pkg::REG_SOCIAL:    soc_r = data;
			psue_pkg::REG_SPEED:     speed_r = data[psue_pkg::LIM_W-1:0];
			psue_pkg::REG_LOWER:     lower_r = data;
			psue_pkg::REG_UPPER:     upper_r = data;
			psue_pkg::REG_SPAN:      span_r = data[psue_pkg::LIM_W-1:0];
			psue_pkg::REG_DIMS:      dims_r = data[psue_pkg::DIMS_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_index = idx;
		cfg_data = data;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic set_regs(logic [15:0] ig, logic [15:0] cg, logic [15:0] sg, logic [15:0] sp,
		logic [15:0] lo, logic [15:0] hi, logic [15:0] wr, logic [15:0] dm);
		wait_drained();
		// Leave the block idle for a while before the registers change.
		repeat (SETTLE) @(posedge clk);
		write_reg(psue_pkg::REG_INERTIA, ig);
		write_reg(psue_pkg::REG_COGNITIVE, cg);
		write_reg(psue_pkg::REG_SOCIAL, sg);
		write_reg(psue_pkg::REG_SPEED, sp);
		write_reg(psue_pkg::REG_LOWER, lo);
		write_reg(psue_pkg::REG_UPPER, hi);
		write_reg(psue_pkg::REG_SPAN, wr);
		write_reg(psue_pkg::REG_DIMS, dm);
	endtask

	task automatic op(logic [1:0] a, int p, int d, int pos, int vel, int ro, int rs,
		logic [31:0] fit);
		swarm_op_t it;
		it.act = a;
		it.p = 6'(p);
		it.d = 6'(d);
		it.pos = 16'(pos);
		it.vel = 16'(vel);
		it.ro = 16'(ro);
		it.rs = 16'(rs);
		it.fit = fit;
		issue(it);
	endtask

	task automatic random_phase();
		quiet = $urandom_range(0, 1);
		repeat (PHASE_ITEMS / 2) gen_random();
		// Hold the sender until everything issued so far has come back.
		wait_drained();
		quiet = ~quiet;
		repeat (PHASE_ITEMS - PHASE_ITEMS / 2) gen_random();
	endtask

	// Driver: presents queued beats on the falling edge.
	always @(negedge clk) begin : driver
		swarm_op_t nx;
		if (arst_n) begin
			if (!in_valid || in_took) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (swarm_ops.size() > 0) begin
					nx = swarm_ops.pop_front();
					action <= nx.act;
					particle <= nx.p;
					dim_index <= nx.d;
					position_in <= nx.pos;
					velocity_in <= nx.vel;
					rand_own <= nx.ro;
					rand_swarm <= nx.rs;
					fitness <= nx.fit;
					in_valid <= 1'b1;
					send_gap = pick_gap();
				end else begin
					in_valid <= 1'b0;
				end
			end
			if (recv_gap > 0) begin
				recv_gap--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if ($urandom_range(0, 3) == 0) recv_gap = pick_gap();
			end
		end
	end

	// Monitor and watchdog on the rising edge.
	always @(posedge clk) begin : monitor
		swarm_res_t ex;
		if (arst_n) begin
			in_took = in_valid && in_ready;
			if (out_valid && out_ready) begin
				if (expected_beats.size() == 0) begin
					report_mismatch("result beat with nothing expected");
				end else begin
					ex = expected_beats.pop_front();
					checked++;
					if (new_position !== ex.npos)
						report_mismatch($sformatf("new_position exp %0d got %0d",
							ex.npos, new_position));
					if (new_velocity !== ex.nvel)
						report_mismatch($sformatf("new_velocity exp %0d got %0d",
							ex.nvel, new_velocity));
					if (best_particle !== ex.bp)
						report_mismatch($sformatf("best_particle exp %0d got %0d",
							ex.bp, best_particle));
					if (best_fitness !== ex.bf)
						report_mismatch($sformatf("best_fitness exp %0h got %0h",
							ex.bf, best_fitness));
					if (improved !== ex.imp)
						report_mismatch($sformatf("improved exp %0b got %0b",
							ex.imp, improved));
				end
			end
			if (in_took || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCH_LIMIT) begin
				$display("Watchdog expired with %0d results outstanding",
					expected_beats.size());
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		out_ready = 1'b0;
		action = psue_pkg::ACT_CLEAR;
		particle = '0;
		dim_index = '0;
		position_in = '0;
		velocity_in = '0;
		rand_own = '0;
		rand_swarm = '0;
		fitness = '0;
		in_took = 1'b0;
		quiet = 1'b0;
		send_gap = 0;
		recv_gap = 0;
		idle_cycles = 0;
		fails = 0;
		checked = 0;
		n_moves = 0;
		n_loads = 0;
		n_improved = 0;
		n_clears = 0;
		foreach (pos_m[i, j]) begin
			pos_m[i][j] = '0;
			vel_m[i][j] = '0;
			obest_m[i][j] = '0;
			pos_wr[i][j] = 1'b0;
			obest_wr[i][j] = 1'b0;
		end
		foreach (obf_m[i]) obf_m[i] = psue_pkg::FIT_WORST;
		gbest_m = '0;
		inertia_r = psue_pkg::RST_INERTIA;
		cog_r = psue_pkg::RST_COGNITIVE;
		soc_r = psue_pkg::RST_SOCIAL;
		speed_r = psue_pkg::RST_SPEED;
		lower_r = psue_pkg::RST_LOWER;
		upper_r = psue_pkg::RST_UPPER;
		span_r = psue_pkg::RST_SPAN;
		dims_r = psue_pkg::RST_DIMS;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: defaults with a four-element copy.
		set_regs(psue_pkg::RST_INERTIA, psue_pkg::RST_COGNITIVE, psue_pkg::RST_SOCIAL,
			16'(psue_pkg::RST_SPEED), psue_pkg::RST_LOWER, psue_pkg::RST_UPPER,
			16'(psue_pkg::RST_SPAN), 16'd4);
		op(psue_pkg::ACT_REPORT, 5, 0, 0, 0, 0, 0, psue_pkg::FIT_WORST);
		op(psue_pkg::ACT_LOAD, 0, 0, 32767, -32768, 0, 0, 0);
		op(psue_pkg::ACT_LOAD, 0, 1, -32768, 32767, 0, 0, 0);
		op(psue_pkg::ACT_LOAD, 0, 2, 0, 0, 0, 0, 0);
		op(psue_pkg::ACT_LOAD, 0, 3, 4000, 100, 0, 0, 0);
		for (int d = 0; d < 4; d++)
			op(psue_pkg::ACT_LOAD, 63, d, -100 * d, 50 * d, 0, 0, 0);
		op(psue_pkg::ACT_LOAD, 63, 63, -4096, 8192, 0, 0, 0);
		op(psue_pkg::ACT_REPORT, 0, 0, 0, 0, 0, 0, 32'd1000);
		op(psue_pkg::ACT_REPORT, 63, 0, 0, 0, 0, 0, 32'd0);
		op(psue_pkg::ACT_REPORT, 63, 0, 0, 0, 0, 0, 32'd0);
		op(psue_pkg::ACT_REPORT, 0, 0, 0, 0, 0, 0, 32'd1000);
		op(psue_pkg::ACT_MOVE, 0, 0, 0, 0, 65535, 65535, 0);
		op(psue_pkg::ACT_MOVE, 0, 1, 0, 0, 0, 0, 0);
		op(psue_pkg::ACT_MOVE, 0, 3, 0, 0, 32768, 12345, 0);
		op(psue_pkg::ACT_MOVE, 63, 0, 0, 0, 65535, 0, 0);
		op(psue_pkg::ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0);
		op(psue_pkg::ACT_REPORT, 0, 0, 0, 0, 0, 0, 32'd5);
		op(psue_pkg::ACT_REPORT, 63, 0, 0, 0, 0, 0, 32'd4);
		op(psue_pkg::ACT_MOVE, 63, 2, 0, 0, 1, 65535, 0);
		random_phase();

		set_regs(16'($urandom_range(0, 8191)), 16'($urandom_range(0, 16383)),
			16'($urandom_range(0, 16383)), 16'($urandom_range(1, 16383)),
			16'(-$urandom_range(0, 12288)), 16'($urandom_range(0, 12288)),
			16'($urandom_range(0, 24576)), 16'($urandom_range(1, 8)));
		random_phase();

		set_regs(16'hffff, 16'hffff, 16'hffff, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff, 16'd1);
		random_phase();

		set_regs(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
			16'h0000);
		random_phase();

		// Full-row copy: the last particle gets every element loaded first.
		set_regs(16'($urandom_range(0, 6000)), 16'($urandom_range(0, 12000)),
			16'($urandom_range(0, 12000)), 16'($urandom_range(100, 12000)), -16'sd8192,
			16'sd8192, 16'd16384, 16'd127);
		for (int d = 0; d < ND; d++)
			op(psue_pkg::ACT_LOAD, 63, d, int'(16'($urandom)), int'(16'($urandom)), 0, 0, 0);
		random_phase();

		set_regs(psue_pkg::RST_INERTIA, 16'd12000, 16'd3000, 16'd4096, -16'sd2048, 16'sd6000,
			16'd5000, 16'd8);
		random_phase();

		wait_drained();
		repeat (SETTLE) @(posedge clk);
		$display("Checked %0d results: %0d loads, %0d moves, %0d clears, %0d improvements",
			checked, n_loads, n_moves, n_clears, n_improved);
		$display("Six register settings, including all-max and all-zero, with %0d mismatches",
			fails);
		if (fails == 0) $display("Regression PASS");
		else $display("Regression FAIL");
		$finish;
	end

endmodule
